@@ design/met_pkg.sv @@
package met_pkg;

  localparam int unsigned MaxIterDefault = 32;
  localparam int unsigned FracBits       = 24;
  localparam int unsigned CountMax       = 31;

  typedef struct packed {
    logic signed [31:0] point_re;
    logic signed [31:0] point_im;
  } in_t;

  typedef struct packed {
    logic [4:0] escape_count;
    logic [6:0] glyph;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_CHECK,
    ST_UPDATE,
    ST_DONE
  } state_e;

  // Escape radius squared, 4.0 in unsigned Q17.48.
  localparam logic [64:0] LimitSq = 65'(4) << 48;

  function automatic logic [6:0] shade_glyph(input logic [4:0] count);
    logic [6:0] g;
    case (count)
      5'd0:                g = 7'd32;   // space
      5'd1:                g = 7'd46;   // '.'
      5'd2:                g = 7'd58;   // ':'
      5'd3, 5'd4:          g = 7'd43;   // '+'
      5'd5, 5'd6:          g = 7'd120;  // 'x'
      5'd7, 5'd8, 5'd9:    g = 7'd88;   // 'X'
      5'd10, 5'd11, 5'd12,
      5'd13, 5'd14, 5'd15: g = 7'd37;   // '%'
      default:             g = 7'd35;   // '#'
    endcase
    return g;
  endfunction

  function automatic logic signed [31:0] sat_q824(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -42'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/mandelbrot_escape_time_top.sv @@
// Escape-time unit for one point c of the Mandelbrot set, Q8.24 inputs.
// One signed 32x32 multiplier is shared: each iteration runs through the states x*x,
// y*y, escape test with x*y, and update. A point that escapes leaves at the escape
// test; one that never escapes runs all MAX_ITER iterations. A new point is taken only
// in idle, once the last result is in the output register; a stalled result holds it back.
// rst_ni is asynchronous, active low; it clears the sequencer and the result valid.
module mandelbrot_escape_time_top
  import met_pkg::*;
#(
  parameter int unsigned MAX_ITER = MaxIterDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned StepW = $clog2(MAX_ITER + 1);

  state_e state_q, state_d;

  logic signed [31:0] cre_q, cim_q;
  logic signed [31:0] x_q, y_q;
  logic signed [63:0] prod_q;
  logic [63:0]        xx_q;
  logic signed [63:0] diff_q;
  logic [StepW-1:0]   step_q;
  logic [4:0]         cnt_q;
  logic               out_valid_q;
  out_t               out_data_q;

  logic               in_fire;
  logic               escaped;
  logic               last_step;
  logic               out_free;
  logic [64:0]        mag;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] mul_res;
  logic signed [40:0] xy_shift;
  logic signed [39:0] diff_shift;
  logic signed [31:0] x_next, y_next;
  logic [4:0]         step_cnt;

  assign in_fire  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Shared multiplier operand selection.
  always_comb begin
    op_a = x_q;
    op_b = x_q;
    case (state_q)
      ST_SQ_Y: begin
        op_a = y_q;
        op_b = y_q;
      end
      ST_CHECK: begin
        op_a = x_q;
        op_b = y_q;
      end
      default: begin
        op_a = x_q;
        op_b = x_q;
      end
    endcase
  end

  assign mul_res = op_a * op_b;

  assign mag     = {1'b0, xx_q} + {1'b0, prod_q};
  assign escaped = mag > LimitSq;

  // 2*x*y shifted down by the fraction width, rounding toward minus infinity.
  assign xy_shift   = prod_q[63:FracBits-1];
  assign diff_shift = diff_q[63:FracBits];
  assign y_next     = sat_q824(42'(xy_shift) + 42'(cim_q));
  assign x_next     = sat_q824(42'(diff_shift) + 42'(cre_q));

  assign last_step = step_q == StepW'(MAX_ITER - 1);
  assign step_cnt  = (32'(step_q) > CountMax) ? 5'(CountMax) : 5'(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SQ_X;
      end
      ST_SQ_X: state_d = ST_SQ_Y;
      ST_SQ_Y: state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = escaped ? ST_DONE : ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = last_step ? ST_DONE : ST_SQ_X;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cre_q  <= in_data_i.point_re;
          cim_q  <= in_data_i.point_im;
          x_q    <= '0;
          y_q    <= '0;
          step_q <= '0;
        end
      end
      ST_SQ_X: begin
        prod_q <= mul_res;
      end
      ST_SQ_Y: begin
        xx_q   <= prod_q;
        prod_q <= mul_res;
      end
      ST_CHECK: begin
        diff_q <= $signed(xx_q) - prod_q;
        prod_q <= mul_res;
        if (escaped) cnt_q <= step_cnt;
      end
      ST_UPDATE: begin
        x_q    <= x_next;
        y_q    <= y_next;
        step_q <= step_q + 1'b1;
        if (last_step) cnt_q <= '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_data_q.escape_count <= cnt_q;
      out_data_q.glyph        <= shade_glyph(cnt_q);
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ design/met_checker.sv @@
module met_checker
  import met_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // The unit holds off new points while one is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a point is in flight");

  // A blank glyph marks exactly the points that never escaped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.escape_count == 5'd0) == (out_data_o.glyph == 7'd32)))
    else $error("glyph does not match escape count");

  // A result cannot appear in the cycle after a point is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared too early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result beat changed");

endmodule

bind mandelbrot_escape_time_top met_checker u_met_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
